>>> rtl/ttt_pkg.sv
package ttt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W = $clog2(TABLE_DEPTH);

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_LOOKUP = 3'd1;
	localparam logic [2:0] CMD_NEWER  = 3'd2;
	localparam logic [2:0] CMD_PURGE  = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;
	localparam logic [2:0] CMD_TICK   = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [31:0] dest;
		logic [31:0] hop;
		logic [15:0] seq;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] found_seq;
		logic [31:0] found_time;
		logic        table_changed;
		logic [31:0] next_expiry;
		logic        next_valid;
	} result_t;

endpackage

>>> rtl/ttt_cell.sv
module ttt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ttt_pkg::entry_t d,
	output ttt_pkg::entry_t q
);

	logic        valid_q;
	logic [31:0] dest_q;
	logic [31:0] hop_q;
	logic [15:0] seq_q;
	logic [31:0] expiry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			dest_q   <= d.dest;
			hop_q    <= d.hop;
			seq_q    <= d.seq;
			expiry_q <= d.expiry;
		end
	end

	assign q = {valid_q, dest_q, hop_q, seq_q, expiry_q};

endmodule

>>> rtl/ttt_scan.sv
module ttt_scan (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             step,
	input  logic [2:0]       cmd,
	input  logic [31:0]      dest_ip,
	input  logic [31:0]      last_hop_ip,
	input  logic [15:0]      seq_num,
	input  logic [31:0]      time_value,
	input  ttt_pkg::entry_t  entry_in,
	output ttt_pkg::entry_t  entry_out,
	output ttt_pkg::result_t result
);

	logic [2:0]  cmd_q;
	logic [31:0] dest_q;
	logic [31:0] hop_q;
	logic [15:0] seq_q;
	logic [31:0] time_q;

	logic        hit_q, placed_q, changed_q, have_q;
	logic [31:0] best_q;
	logic [15:0] fseq_q;
	logic [31:0] ftime_q;

	logic        hit_n, placed_n, changed_n;
	logic [15:0] fseq_n;
	logic [31:0] ftime_n;
	logic        key_m, hop_m;

	assign key_m = entry_in.valid && entry_in.dest == dest_q && entry_in.hop == hop_q;
	assign hop_m = entry_in.valid && entry_in.hop == hop_q;

	always_comb begin
		entry_out = entry_in;
		hit_n     = hit_q;
		placed_n  = placed_q;
		changed_n = changed_q;
		fseq_n    = fseq_q;
		ftime_n   = ftime_q;
		case (cmd_q)
			ttt_pkg::CMD_INSERT: begin
				if (key_m) begin
					// key already placed in an earlier free slot: drop the old copy
					if (placed_q) begin
						entry_out.valid = 1'b0;
					end else begin
						entry_out.seq    = seq_q;
						entry_out.expiry = time_q;
						placed_n         = 1'b1;
					end
				end else if (!entry_in.valid && !placed_q) begin
					entry_out.valid  = 1'b1;
					entry_out.dest   = dest_q;
					entry_out.hop    = hop_q;
					entry_out.seq    = seq_q;
					entry_out.expiry = time_q;
					placed_n         = 1'b1;
				end
			end
			ttt_pkg::CMD_LOOKUP: begin
				if (key_m) begin
					hit_n   = 1'b1;
					fseq_n  = entry_in.seq;
					ftime_n = entry_in.expiry;
				end
			end
			ttt_pkg::CMD_NEWER: begin
				if (hop_m && entry_in.seq > seq_q) begin
					hit_n = 1'b1;
				end
			end
			ttt_pkg::CMD_PURGE: begin
				if (hop_m && entry_in.seq < seq_q) begin
					entry_out.valid = 1'b0;
					changed_n       = 1'b1;
				end
			end
			ttt_pkg::CMD_REMOVE: begin
				if (key_m) begin
					entry_out.valid = 1'b0;
					changed_n       = 1'b1;
				end
			end
			ttt_pkg::CMD_TICK: begin
				if (entry_in.valid && entry_in.expiry <= time_q) begin
					entry_out.valid = 1'b0;
					changed_n       = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cmd_q  <= cmd;
			dest_q <= dest_ip;
			hop_q  <= last_hop_ip;
			seq_q  <= seq_num;
			time_q <= time_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q     <= 1'b0;
			placed_q  <= 1'b0;
			changed_q <= 1'b0;
			have_q    <= 1'b0;
			best_q    <= '0;
			fseq_q    <= '0;
			ftime_q   <= '0;
		end else if (start) begin
			hit_q     <= 1'b0;
			placed_q  <= 1'b0;
			changed_q <= 1'b0;
			have_q    <= 1'b0;
			best_q    <= '0;
			fseq_q    <= '0;
			ftime_q   <= '0;
		end else if (step) begin
			hit_q     <= hit_n;
			placed_q  <= placed_n;
			changed_q <= changed_n;
			fseq_q    <= fseq_n;
			ftime_q   <= ftime_n;
			// track the earliest expiry among entries left in the ring
			if (entry_out.valid && (!have_q || entry_out.expiry < best_q)) begin
				have_q <= 1'b1;
				best_q <= entry_out.expiry;
			end
		end
	end

	always_comb begin
		result = '0;
		case (cmd_q)
			ttt_pkg::CMD_INSERT: begin
				result.status      = placed_q ? ttt_pkg::ST_OK : ttt_pkg::ST_FULL;
				result.next_expiry = have_q ? best_q : 32'd0;
				result.next_valid  = have_q;
			end
			ttt_pkg::CMD_LOOKUP: begin
				result.status     = hit_q ? ttt_pkg::ST_OK : ttt_pkg::ST_NOTFOUND;
				result.found_seq  = fseq_q;
				result.found_time = ftime_q;
			end
			ttt_pkg::CMD_NEWER: begin
				result.status = hit_q ? ttt_pkg::ST_OK : ttt_pkg::ST_NOTFOUND;
			end
			ttt_pkg::CMD_PURGE, ttt_pkg::CMD_REMOVE: begin
				result.status        = changed_q ? ttt_pkg::ST_OK : ttt_pkg::ST_NOTFOUND;
				result.table_changed = changed_q;
			end
			ttt_pkg::CMD_TICK: begin
				result.status        = ttt_pkg::ST_OK;
				result.table_changed = changed_q;
				result.next_expiry   = have_q ? best_q : 32'd0;
				result.next_valid    = have_q;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/topology_tuple_table.sv
// Topology tuple table: up to TABLE_DEPTH link tuples keyed by
// (dest_ip, last_hop_ip), each with a sequence number and expiry time.
// Input channel: in_valid / in_stall carry one command beat (cmd and its
// fields). Output channel: out_valid / out_stall carry one result beat per
// command.
// The tuples sit in a ring of cells that rotates one place per cycle while
// a command runs; a single scan unit at the head of the ring sees every
// tuple once and updates, removes or inserts it on the way past.
// One command is in flight at a time, and its result is gathered over
// one full rotation of the ring.
// in_stall is high while a command is in flight. If the receiver stalls,
// the finished result waits in the scan unit and the output register
// holds its beat; no new command is taken until the result is loaded.
// Reset clears every tuple's valid bit at once and empties the output;
// no clearing pass is needed.
module topology_tuple_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] dest_ip,
	input  logic [31:0] last_hop_ip,
	input  logic [15:0] seq_num,
	input  logic [31:0] time_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] found_seq,
	output logic [31:0] found_time,
	output logic        table_changed,
	output logic [31:0] next_expiry,
	output logic        next_valid
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                state_q;
	logic [ttt_pkg::CNT_W-1:0] cnt_q;
	logic                      start, step, load;

	ttt_pkg::entry_t  ring [ttt_pkg::TABLE_DEPTH];
	ttt_pkg::entry_t  head_out;
	ttt_pkg::result_t res;

	assign in_stall = (state_q != S_IDLE);
	assign start    = in_valid && (state_q == S_IDLE);
	assign step     = (state_q == S_SCAN);
	assign load     = (state_q == S_DONE) && (!out_valid || !out_stall);

	for (genvar i = 0; i < ttt_pkg::TABLE_DEPTH; i++) begin : g_cell
		if (i == ttt_pkg::TABLE_DEPTH - 1) begin : g_tail
			ttt_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(step),
				.d(head_out), .q(ring[i]));
		end else begin : g_body
			ttt_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(step),
				.d(ring[i+1]), .q(ring[i]));
		end
	end

	ttt_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.step       (step),
		.cmd        (cmd),
		.dest_ip    (dest_ip),
		.last_hop_ip(last_hop_ip),
		.seq_num    (seq_num),
		.time_value (time_value),
		.entry_in   (ring[0]),
		.entry_out  (head_out),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_SCAN;
						cnt_q   <= '0;
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ttt_pkg::CNT_W'(ttt_pkg::TABLE_DEPTH - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status        <= res.status;
			found_seq     <= res.found_seq;
			found_time    <= res.found_time;
			table_changed <= res.table_changed;
			next_expiry   <= res.next_expiry;
			next_valid    <= res.next_valid;
		end
	end

endmodule
